// ===== rtl/core/oams_pkg.sv =====
// Package for the obstacle-avoidance motion sequencer: transaction types, command codes,
// the command sequence table and the motor drive decode.
// No dependencies.
package oams_pkg;

    localparam int WIDTH_BITS = 16;

    typedef enum logic [2:0] {
        CMD_S = 3'd0,
        CMD_F = 3'd1,
        CMD_B = 3'd2,
        CMD_R = 3'd3,
        CMD_L = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] front_width;
        logic [WIDTH_BITS-1:0] back_width;
        logic [WIDTH_BITS-1:0] left_width;
        logic [WIDTH_BITS-1:0] right_width;
    } in_t;

    typedef struct packed {
        logic [2:0] move_command;
        logic       right_fwd_drive;
        logic       left_fwd_drive;
        logic       right_rev_drive;
        logic       left_rev_drive;
        logic       last_of_run;
    } out_t;

    // Commands are listed first to last; last_idx is the position of the final one.
    typedef struct packed {
        logic [1:0] last_idx;
        cmd_t       c0;
        cmd_t       c1;
        cmd_t       c2;
        cmd_t       c3;
    } seq_t;

    localparam int NUM_STATES = 5;
    localparam int NUM_CODES  = 16;

    localparam seq_t SEQ_TABLE [NUM_STATES][NUM_CODES] = '{
        '{  // not moving
            '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_R, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_L, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S}, '{2'd1, CMD_F, CMD_R, CMD_S, CMD_S},
            '{2'd1, CMD_F, CMD_L, CMD_S, CMD_S}, '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_B, CMD_S, CMD_S, CMD_S}, '{2'd1, CMD_B, CMD_R, CMD_S, CMD_S},
            '{2'd1, CMD_B, CMD_L, CMD_S, CMD_S}, '{2'd0, CMD_B, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_R, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_R, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_L, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}
        },
        '{  // forward
            '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_L, CMD_S, CMD_S}, '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S}, '{2'd3, CMD_S, CMD_F, CMD_S, CMD_R},
            '{2'd3, CMD_S, CMD_F, CMD_S, CMD_L}, '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_B, CMD_S, CMD_S}, '{2'd3, CMD_S, CMD_B, CMD_S, CMD_R},
            '{2'd3, CMD_S, CMD_B, CMD_S, CMD_L}, '{2'd1, CMD_S, CMD_B, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_L, CMD_S, CMD_S}, '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}
        },
        '{  // backward
            '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_L, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S}, '{2'd3, CMD_S, CMD_F, CMD_S, CMD_R},
            '{2'd3, CMD_S, CMD_F, CMD_S, CMD_L}, '{2'd0, CMD_F, CMD_S, CMD_S, CMD_S},
            '{2'd0, CMD_B, CMD_S, CMD_S, CMD_S}, '{2'd2, CMD_B, CMD_S, CMD_R, CMD_S},
            '{2'd2, CMD_B, CMD_S, CMD_L, CMD_S}, '{2'd0, CMD_B, CMD_S, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_L, CMD_S, CMD_S}, '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}
        },
        '{  // turning right
            '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_R, CMD_S, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_L, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S}, '{2'd1, CMD_F, CMD_R, CMD_S, CMD_S},
            '{2'd3, CMD_S, CMD_F, CMD_S, CMD_L}, '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_B, CMD_S, CMD_S}, '{2'd2, CMD_B, CMD_S, CMD_R, CMD_S},
            '{2'd3, CMD_S, CMD_B, CMD_S, CMD_L}, '{2'd1, CMD_S, CMD_B, CMD_S, CMD_S},
            '{2'd0, CMD_R, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_R, CMD_S, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_L, CMD_S, CMD_S}, '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}
        },
        '{  // turning left
            '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S},
            '{2'd0, CMD_L, CMD_S, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S}, '{2'd3, CMD_S, CMD_F, CMD_S, CMD_R},
            '{2'd1, CMD_F, CMD_L, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_F, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_B, CMD_S, CMD_S}, '{2'd3, CMD_S, CMD_B, CMD_S, CMD_R},
            '{2'd1, CMD_B, CMD_L, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_B, CMD_S, CMD_S},
            '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S}, '{2'd1, CMD_S, CMD_R, CMD_S, CMD_S},
            '{2'd0, CMD_L, CMD_S, CMD_S, CMD_S}, '{2'd0, CMD_S, CMD_S, CMD_S, CMD_S}
        }
    };

    // Drive levels in the order right forward, left forward, right reverse, left reverse.
    function automatic logic [3:0] drive_of(cmd_t cmd);
        logic [3:0] drv;
        unique case (cmd)
            CMD_F:   drv = 4'b1100;
            CMD_B:   drv = 4'b0011;
            CMD_R:   drv = 4'b0110;
            CMD_L:   drv = 4'b1001;
            default: drv = 4'b0000;
        endcase
        return drv;
    endfunction

endpackage

// ===== rtl/core/obstacle_avoidance_motion_sequencer.sv =====
// Top level of the obstacle-avoidance motion sequencer: danger decode, sequence lookup,
// command queue and output register.
// Depends on oams_pkg.
// The first command of a transaction passes through the command queue and then the output register.
// Throughput: one command per cycle when the output is not stalled by m_ready, so a reading set
// yields one to four commands, set by its sequence length; the next input is taken as the last leaves.
// Reset (aresetn low, synchronous) clears the threshold, the motion state and all valids.
module obstacle_avoidance_motion_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [oams_pkg::WIDTH_BITS-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  oams_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output oams_pkg::out_t                  m_data
);
    import oams_pkg::*;

    logic [WIDTH_BITS-1:0] thresh_reg;
    cmd_t                  state_reg;
    cmd_t                  state_next;
    logic                  seq_valid_reg;
    logic                  seq_valid_next;
    cmd_t                  seq_cmds_reg [4];
    cmd_t                  seq_cmds_next [4];
    logic [1:0]            seq_left_reg;
    logic [1:0]            seq_left_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_t                  out_data_reg;
    out_t                  out_data_next;

    logic       s_accept;
    logic       out_load;
    logic       seq_done;
    logic [3:0] danger_code;
    logic [2:0] st_idx;
    seq_t       seq_sel;
    logic [3:0] drv;

    function automatic logic is_danger(logic [WIDTH_BITS-1:0] w, logic [WIDTH_BITS-1:0] t);
        return (t > w) && (w != WIDTH_BITS'(1));
    endfunction

    assign cfg_ready = 1'b1;

    assign out_load = seq_valid_reg && (!out_valid_reg || m_ready);
    assign seq_done = out_load && (seq_left_reg == 2'd0);
    assign s_ready  = !seq_valid_reg || seq_done;
    assign s_accept = s_valid && s_ready;

    assign danger_code = {is_danger(s_data.front_width, thresh_reg),
                          is_danger(s_data.back_width,  thresh_reg),
                          is_danger(s_data.right_width, thresh_reg),
                          is_danger(s_data.left_width,  thresh_reg)};
    assign st_idx  = (state_reg <= CMD_L) ? 3'(state_reg) : 3'(CMD_S);
    assign seq_sel = SEQ_TABLE[st_idx][danger_code];
    assign drv     = drive_of(seq_cmds_reg[0]);

    always_comb begin
        state_next     = state_reg;
        seq_valid_next = seq_valid_reg;
        seq_left_next  = seq_left_reg;
        seq_cmds_next  = seq_cmds_reg;
        if (out_load) begin
            seq_cmds_next[0] = seq_cmds_reg[1];
            seq_cmds_next[1] = seq_cmds_reg[2];
            seq_cmds_next[2] = seq_cmds_reg[3];
            seq_left_next    = seq_left_reg - 2'd1;
            if (seq_done) begin
                seq_valid_next = 1'b0;
            end
        end
        if (s_accept) begin
            seq_valid_next   = 1'b1;
            seq_left_next    = seq_sel.last_idx;
            seq_cmds_next[0] = seq_sel.c0;
            seq_cmds_next[1] = seq_sel.c1;
            seq_cmds_next[2] = seq_sel.c2;
            seq_cmds_next[3] = seq_sel.c3;
            unique case (seq_sel.last_idx)
                2'd0: state_next = seq_sel.c0;
                2'd1: state_next = seq_sel.c1;
                2'd2: state_next = seq_sel.c2;
                2'd3: state_next = seq_sel.c3;
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next               = 1'b1;
            out_data_next.move_command    = 3'(seq_cmds_reg[0]);
            out_data_next.right_fwd_drive = drv[3];
            out_data_next.left_fwd_drive  = drv[2];
            out_data_next.right_rev_drive = drv[1];
            out_data_next.left_rev_drive  = drv[0];
            out_data_next.last_of_run     = (seq_left_reg == 2'd0);
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg    <= '0;
            state_reg     <= CMD_S;
            seq_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            state_reg     <= state_next;
            seq_valid_reg <= seq_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_cmds_reg <= seq_cmds_next;
        seq_left_reg <= seq_left_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A loaded sequence always ends in the command now held as the motion state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (seq_cmds_reg[seq_left_reg] == state_reg))
        else $error("Motion state does not match the last queued command.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> seq_valid_reg)
        else $error("Accepted transaction was not queued.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_done && !s_accept) |=> !seq_valid_reg)
        else $error("Command queue still busy after its last command.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (seq_left_reg != 2'd0)) |=> seq_valid_reg)
        else $error("Command queue drained before its last command.");

endmodule
